@@ src/old_pkg.sv @@
// Shared types and codes for the ordered list block.
// Used by old_ctrl, old_dp and ordered_list_with_delete_ops_top; depends on nothing.
package old_pkg;

    localparam logic [2:0] MODE_APPEND    = 3'd0;
    localparam logic [2:0] MODE_DEL_HEAD  = 3'd1;
    localparam logic [2:0] MODE_DEL_TAIL  = 3'd2;
    localparam logic [2:0] MODE_DEL_VALUE = 3'd3;
    localparam logic [2:0] MODE_DUMP      = 3'd4;

    localparam logic [1:0] ST_DONE       = 2'd0;
    localparam logic [1:0] ST_NONE       = 2'd1;
    localparam logic [1:0] ST_FULL       = 2'd2;
    localparam logic [1:0] ST_EMPTY_DUMP = 2'd3;

    localparam int unsigned LEN_W = 5;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       accept;        // latch the incoming value
        logic       app_write;     // write the value at the tail, count up
        logic       dec_count;     // count down by one
        logic       walk_start;    // reset the read walk
        logic       walk_from_one; // walk starts at the second entry
        logic       set_status;    // load the pending status code
        logic [1:0] status;
        logic       search;        // compare entries with the value
        logic       shift;         // move each entry read up by one slot
        logic       dump;          // send each entry read to the output
        logic       finish_load;   // load the pending status into the output
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic count_zero;
        logic full;
        logic match;
        logic walk_done;
        logic dump_last;
        logic out_free;
    } t_stat;

endpackage

@@ src/ordered_list_with_delete_ops_top.sv @@
// Top level of the bounded ordered list with delete operations.
// Depends on old_pkg, old_ctrl and old_dp.
//
// Usage:
//   The input channel (i_valid, o_ready, i_mode, i_value) takes one operation per
//   transaction: append, delete head, delete tail, delete first match, or dump.
//   The output channel (o_valid, i_ready, o_entry, o_status, o_is_last, o_length)
//   returns one status transaction per operation, or one transaction per entry for
//   a dump, with o_is_last set on the final one.
//   Sequencing: append, delete tail, undefined modes and any operation on an empty
//   list go straight from acceptance to the finish state, which loads the result
//   into the output register once it is free. Delete head and delete by value walk
//   the entry memory one entry per cycle through its registered read port, then
//   finish the same way. A dump loads its entries into the output register one
//   by one in list order.
//   The next operation is accepted in the cycle after the last result is loaded
//   into the output register, even if that result is still waiting.
//   Reset (i_rst_n low at a clock edge) empties the list and drops any pending
//   result; the memory contents are not cleared. When the receiver stalls, the
//   output register holds its transaction and a dump pauses its memory walk.
module ordered_list_with_delete_ops_top #(
    parameter int DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [2:0]         i_mode,
    input  logic signed [31:0] i_value,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_entry,
    output logic [1:0]         o_status,
    output logic               o_is_last,
    output logic [4:0]         o_length
);

    old_pkg::t_cmd  cmd;
    old_pkg::t_stat stat;

    // The controller sequences each operation; the datapath holds all storage.
    old_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_mode  (i_mode),
        .i_stat  (stat),
        .o_ready (o_ready),
        .o_cmd   (cmd)
    );

    old_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_value     (i_value),
        .i_out_ready (i_ready),
        .o_stat      (stat),
        .o_out_valid (o_valid),
        .o_entry     (o_entry),
        .o_status    (o_status),
        .o_is_last   (o_is_last),
        .o_length    (o_length)
    );

endmodule

@@ src/old_ctrl.sv @@
// Controller state machine of the ordered list block.
// Depends on old_pkg; drives old_dp through t_cmd and reads t_stat.
module old_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [2:0]     i_mode,
    input  old_pkg::t_stat i_stat,
    output logic           o_ready,
    output old_pkg::t_cmd  o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SEARCH = 5'b00010,
        S_SHIFT  = 5'b00100,
        S_DUMP   = 5'b01000,
        S_FINISH = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    case (i_mode)
                        old_pkg::MODE_APPEND: begin
                            o_cmd.set_status = 1'b1;
                            if (i_stat.full) begin
                                o_cmd.status = old_pkg::ST_FULL;
                            end else begin
                                o_cmd.app_write = 1'b1;
                                o_cmd.status    = old_pkg::ST_DONE;
                            end
                            n_state = S_FINISH;
                        end
                        old_pkg::MODE_DEL_HEAD: begin
                            if (i_stat.count_zero) begin
                                o_cmd.set_status = 1'b1;
                                o_cmd.status     = old_pkg::ST_NONE;
                                n_state          = S_FINISH;
                            end else begin
                                o_cmd.walk_start    = 1'b1;
                                o_cmd.walk_from_one = 1'b1;
                                n_state             = S_SHIFT;
                            end
                        end
                        old_pkg::MODE_DEL_TAIL: begin
                            o_cmd.set_status = 1'b1;
                            if (i_stat.count_zero) begin
                                o_cmd.status = old_pkg::ST_NONE;
                            end else begin
                                o_cmd.dec_count = 1'b1;
                                o_cmd.status    = old_pkg::ST_DONE;
                            end
                            n_state = S_FINISH;
                        end
                        old_pkg::MODE_DEL_VALUE: begin
                            if (i_stat.count_zero) begin
                                o_cmd.set_status = 1'b1;
                                o_cmd.status     = old_pkg::ST_NONE;
                                n_state          = S_FINISH;
                            end else begin
                                o_cmd.walk_start = 1'b1;
                                n_state          = S_SEARCH;
                            end
                        end
                        old_pkg::MODE_DUMP: begin
                            if (i_stat.count_zero) begin
                                o_cmd.set_status = 1'b1;
                                o_cmd.status     = old_pkg::ST_EMPTY_DUMP;
                                n_state          = S_FINISH;
                            end else begin
                                o_cmd.walk_start = 1'b1;
                                n_state          = S_DUMP;
                            end
                        end
                        default: begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = old_pkg::ST_NONE;
                            n_state          = S_FINISH;
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                o_cmd.search = 1'b1;
                if (i_stat.match) begin
                    n_state = S_SHIFT;
                end else if (i_stat.walk_done) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = old_pkg::ST_NONE;
                    n_state          = S_FINISH;
                end
            end
            S_SHIFT: begin
                o_cmd.shift = 1'b1;
                if (i_stat.walk_done) begin
                    o_cmd.dec_count  = 1'b1;
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = old_pkg::ST_DONE;
                    n_state          = S_FINISH;
                end
            end
            S_DUMP: begin
                o_cmd.dump = 1'b1;
                if (i_stat.dump_last) begin
                    n_state = S_IDLE;
                end
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.finish_load = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ src/old_dp.sv @@
// Datapath of the ordered list block: entry memory, count, read walk, output register.
// Depends on old_pkg; controlled by old_ctrl through t_cmd.
module old_dp #(
    parameter int DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  old_pkg::t_cmd      i_cmd,
    input  logic signed [31:0] i_value,
    input  logic               i_out_ready,
    output old_pkg::t_stat     o_stat,
    output logic               o_out_valid,
    output logic signed [31:0] o_entry,
    output logic [1:0]         o_status,
    output logic               o_is_last,
    output logic [old_pkg::LEN_W-1:0] o_length
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic signed [31:0] r_mem [DEPTH];
    logic [CW-1:0]      r_count;
    logic signed [31:0] r_value;
    logic [CW-1:0]      r_rd_addr;
    logic               r_rvalid;
    logic signed [31:0] r_rdata;
    logic [CW-1:0]      r_ridx;
    logic [1:0]         r_status;

    logic               r_out_valid;
    logic signed [31:0] r_out_entry;
    logic [1:0]         r_out_status;
    logic               r_out_last;
    logic [old_pkg::LEN_W-1:0] r_out_len;

    logic               out_free;
    logic               consume;
    logic               issue;
    logic               dump_load;
    logic               last_ent;
    logic [CW-1:0]      ridx_m1;
    logic [CW-1:0]      count_m1;
    logic               wr_en;
    logic [IW-1:0]      wr_addr;
    logic signed [31:0] wr_data;
    logic [CW+old_pkg::LEN_W-1:0] count_ext;

    assign out_free  = !r_out_valid || i_out_ready;
    assign consume   = i_cmd.dump ? out_free : 1'b1;
    assign issue     = (i_cmd.search || i_cmd.shift || i_cmd.dump)
                       && (r_rd_addr < r_count) && (!r_rvalid || consume);
    assign dump_load = i_cmd.dump && r_rvalid && out_free;
    assign count_m1  = r_count - CW'(1);
    assign ridx_m1   = r_ridx - CW'(1);
    assign last_ent  = (r_ridx == count_m1);
    assign count_ext = {{old_pkg::LEN_W{1'b0}}, r_count};

    assign o_stat.count_zero = (r_count == '0);
    assign o_stat.full       = (r_count == CW'(DEPTH));
    assign o_stat.match      = r_rvalid && (r_rdata == r_value);
    assign o_stat.walk_done  = !r_rvalid && (r_rd_addr >= r_count);
    assign o_stat.dump_last  = dump_load && last_ent;
    assign o_stat.out_free   = out_free;

    // Appends and compaction moves never happen in the same cycle.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_count[IW-1:0];
        wr_data = i_value;
        if (i_cmd.app_write) begin
            wr_en = 1'b1;
        end else if (i_cmd.shift && r_rvalid) begin
            wr_en   = 1'b1;
            wr_addr = ridx_m1[IW-1:0];
            wr_data = r_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (issue) begin
            r_rdata <= r_mem[r_rd_addr[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rvalid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.app_write) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.dec_count) begin
                r_count <= count_m1;
            end

            if (i_cmd.walk_start) begin
                r_rvalid <= 1'b0;
            end else if (issue) begin
                r_rvalid <= 1'b1;
            end else if (consume) begin
                r_rvalid <= 1'b0;
            end

            if (i_cmd.finish_load || dump_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_value <= i_value;
        end
        if (i_cmd.walk_start) begin
            r_rd_addr <= i_cmd.walk_from_one ? CW'(1) : '0;
        end else if (issue) begin
            r_rd_addr <= r_rd_addr + CW'(1);
            r_ridx    <= r_rd_addr;
        end
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status;
        end
        if (i_cmd.finish_load) begin
            r_out_entry  <= '0;
            r_out_status <= r_status;
            r_out_last   <= 1'b1;
            r_out_len    <= count_ext[old_pkg::LEN_W-1:0];
        end else if (dump_load) begin
            r_out_entry  <= r_rdata;
            r_out_status <= old_pkg::ST_DONE;
            r_out_last   <= last_ent;
            r_out_len    <= count_ext[old_pkg::LEN_W-1:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_entry     = r_out_entry;
    assign o_status    = r_out_status;
    assign o_is_last   = r_out_last;
    assign o_length    = r_out_len;

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps
// Testbench for ordered_list_with_delete_ops_top: a bounded list of signed values
// checked against a queue-based list predictor. Depends on old_pkg and the RTL top.
module tb;

    localparam int LIST_DEPTH = 16;

    // Modes 5 to 7 have no defined operation; the block must answer them with a
    // single "nothing to do" status and leave the list alone.
    localparam logic [2:0] MODE_RSVD_LO = 3'd5;
    localparam logic [2:0] MODE_RSVD_HI = 3'd7;

    localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

    typedef struct {
        logic signed [31:0] entry;
        logic [1:0]         status;
        logic               is_last;
        logic [4:0]         length;
    } t_list_result;

    // The scoreboard keeps its own copy of the list, predicts the results of every
    // accepted operation and matches them in order against the output transactions.
    class t_list_scoreboard;
        logic signed [31:0] held[$];
        t_list_result       awaited[$];
        int                 errors;

        function new();
            errors = 0;
        endfunction

        function void expect_result(logic signed [31:0] entry, logic [1:0] status,
                                    logic is_last);
            t_list_result r;
            r.entry   = entry;
            r.status  = status;
            r.is_last = is_last;
            r.length  = 5'(held.size());
            awaited.push_back(r);
        endfunction

        // Apply one accepted operation to the list copy and queue its results.
        function void note_op(logic [2:0] mode, logic signed [31:0] value);
            logic [1:0] status;
            int         hit;
            status = old_pkg::ST_NONE;
            hit    = -1;
            case (mode)
                old_pkg::MODE_APPEND: begin
                    if (held.size() >= LIST_DEPTH) begin
                        status = old_pkg::ST_FULL;
                    end else begin
                        held.push_back(value);
                        status = old_pkg::ST_DONE;
                    end
                end
                old_pkg::MODE_DEL_HEAD: begin
                    if (held.size() > 0) begin
                        void'(held.pop_front());
                        status = old_pkg::ST_DONE;
                    end
                end
                old_pkg::MODE_DEL_TAIL: begin
                    if (held.size() > 0) begin
                        void'(held.pop_back());
                        status = old_pkg::ST_DONE;
                    end
                end
                old_pkg::MODE_DEL_VALUE: begin
                    for (int i = 0; i < held.size(); i++) begin
                        if (hit < 0 && held[i] == value) hit = i;
                    end
                    if (hit >= 0) begin
                        held.delete(hit);
                        status = old_pkg::ST_DONE;
                    end
                end
                old_pkg::MODE_DUMP: begin
                    if (held.size() == 0) begin
                        expect_result('0, old_pkg::ST_EMPTY_DUMP, 1'b1);
                    end else begin
                        for (int i = 0; i < held.size(); i++) begin
                            expect_result(held[i], old_pkg::ST_DONE,
                                          i == held.size() - 1);
                        end
                    end
                    return;
                end
                default: begin
                end
            endcase
            expect_result('0, status, 1'b1);
        endfunction

        function void check_result(logic signed [31:0] entry, logic [1:0] status,
                                   logic is_last, logic [4:0] length);
            t_list_result want;
            if (awaited.size() == 0) begin
                $error("unexpected result: entry %0d status %0d is_last %0d length %0d",
                       entry, status, is_last, length);
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (entry !== want.entry) begin
                $error("entry: expected %0d, got %0d", want.entry, entry);
                errors++;
            end
            if (status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, status);
                errors++;
            end
            if (is_last !== want.is_last) begin
                $error("is_last: expected %0d, got %0d", want.is_last, is_last);
                errors++;
            end
            if (length !== want.length) begin
                $error("length: expected %0d, got %0d", want.length, length);
                errors++;
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function int held_count();
            return held.size();
        endfunction

        // A value that is currently in the list, so that delete by value hits.
        function logic signed [31:0] some_held();
            return held[$urandom_range(held.size() - 1)];
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [2:0]         i_mode = old_pkg::MODE_APPEND;
    logic signed [31:0] i_value = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic signed [31:0] o_entry;
    logic [1:0]         o_status;
    logic               o_is_last;
    logic [4:0]         o_length;

    t_list_scoreboard board;
    int               send_idle_pct = 0;
    int               recv_idle_pct = 0;

    ordered_list_with_delete_ops_top #(
        .DEPTH(LIST_DEPTH)
    ) u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_mode   (i_mode),
        .i_value  (i_value),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_entry  (o_entry),
        .o_status (o_status),
        .o_is_last(o_is_last),
        .o_length (o_length)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // The receiver drops its ready at random, at the rate set for the current phase.
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Values are sampled in the active region right after the edge, so they are the
    // values that the block saw at that edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            board.check_result(o_entry, o_status, o_is_last, o_length);
        end
    end

    // Present one operation and hold it until the block takes it. Before it, the
    // sender may sometimes idle, which lowers valid between transactions.
    task automatic send_op(input logic [2:0] mode, input logic signed [31:0] value);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_mode  <= mode;
        i_value <= value;
        do @(posedge i_clk); while (!o_ready);
        board.note_op(mode, value);
    endtask

    // Hold the input side quiet until every predicted result has come back.
    task automatic drain_results();
        i_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $signed(32'($urandom_range(8))) - 32'sd4;
            2: begin
                case ($urandom_range(3))
                    0: return VAL_MAX;
                    1: return VAL_MIN;
                    2: return 32'sd0;
                    default: return -32'sd1;
                endcase
            end
            default: begin
                // Appending a value already held makes duplicates, so that delete
                // by value has to pick the first of several matches.
                if (board.held_count() > 0) return board.some_held();
                return $urandom;
            end
        endcase
    endfunction

    // Mode mix that either grows the list toward full or shrinks it toward empty.
    function automatic logic [2:0] pick_mode(input bit growing);
        int r;
        r = $urandom_range(99);
        if (growing) begin
            if (r < 70) return old_pkg::MODE_APPEND;
            if (r < 76) return old_pkg::MODE_DEL_HEAD;
            if (r < 82) return old_pkg::MODE_DEL_TAIL;
            if (r < 90) return old_pkg::MODE_DEL_VALUE;
            if (r < 97) return old_pkg::MODE_DUMP;
        end else begin
            if (r < 20) return old_pkg::MODE_APPEND;
            if (r < 38) return old_pkg::MODE_DEL_HEAD;
            if (r < 56) return old_pkg::MODE_DEL_TAIL;
            if (r < 80) return old_pkg::MODE_DEL_VALUE;
            if (r < 95) return old_pkg::MODE_DUMP;
        end
        return 3'($urandom_range(MODE_RSVD_LO, MODE_RSVD_HI));
    endfunction

    task automatic run_random(input int count);
        bit                 growing;
        int                 stretch;
        logic [2:0]         mode;
        logic signed [31:0] value;
        growing = 1'b1;
        stretch = 40;
        for (int n = 0; n < count; n++) begin
            if (stretch == 0) begin
                growing = !growing;
                stretch = $urandom_range(15, 35);
            end
            stretch--;
            mode  = pick_mode(growing);
            value = pick_value();
            // Most searches look for a value that is actually in the list.
            if (mode == old_pkg::MODE_DEL_VALUE && board.held_count() > 0
                && $urandom_range(3) != 0)
                value = board.some_held();
            send_op(mode, value);
        end
    endtask

    // Directed opening: every operation on an empty list, the undefined modes, the
    // extreme values, duplicates, a search that misses, and deletion at the head, in
    // the middle and at the tail until the list is empty again.
    task automatic run_directed();
        send_op(old_pkg::MODE_DUMP, 32'sd0);
        send_op(old_pkg::MODE_DEL_HEAD, 32'sd0);
        send_op(old_pkg::MODE_DEL_TAIL, 32'sd0);
        send_op(old_pkg::MODE_DEL_VALUE, 32'sd0);
        send_op(MODE_RSVD_LO, VAL_MAX);
        send_op(MODE_RSVD_LO + 3'd1, VAL_MIN);
        send_op(MODE_RSVD_HI, -32'sd1);
        send_op(old_pkg::MODE_APPEND, VAL_MAX);
        send_op(old_pkg::MODE_APPEND, VAL_MIN);
        send_op(old_pkg::MODE_APPEND, 32'sd0);
        send_op(old_pkg::MODE_APPEND, VAL_MIN);
        send_op(old_pkg::MODE_APPEND, -32'sd1);
        send_op(old_pkg::MODE_DUMP, 32'sd0);
        send_op(old_pkg::MODE_DEL_VALUE, VAL_MIN);
        send_op(old_pkg::MODE_DEL_VALUE, 32'sd5);
        send_op(old_pkg::MODE_DUMP, 32'sd0);
        send_op(old_pkg::MODE_DEL_HEAD, 32'sd0);
        send_op(old_pkg::MODE_DEL_TAIL, 32'sd0);
        send_op(MODE_RSVD_HI, VAL_MIN);
        send_op(old_pkg::MODE_DUMP, 32'sd0);
        send_op(old_pkg::MODE_DEL_VALUE, VAL_MIN);
        send_op(old_pkg::MODE_DEL_VALUE, 32'sd0);
        send_op(old_pkg::MODE_DUMP, 32'sd0);
    endtask

    initial begin
        board = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // First phase: the receiver stalls far more often than the sender idles.
        send_idle_pct = 17;
        recv_idle_pct = 69;
        run_directed();
        run_random(95);

        // The sender stops until the whole backlog has been returned, so the block
        // sees an idle input with an empty output queue.
        drain_results();

        // Second phase: roles reversed, the sender is the slow side.
        send_idle_pct = 69;
        recv_idle_pct = 17;
        run_random(95);
        drain_results();

        // Third phase: both sides run flat out.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(100);

        drain_results();
        repeat (40) @(posedge i_clk);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("ordered_list_with_delete_ops_top: match");
        end else begin
            $display("ordered_list_with_delete_ops_top: mismatch");
        end
        $finish;
    end

    // Watchdog: a limit far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("ordered_list_with_delete_ops_top: mismatch");
        $finish;
    end

endmodule
